@@ rtl/lcfp_pkg.sv @@
// Shared types, codes and CRC-32 and little-endian byte-insert helper functions of the length and CRC frame parser.
package lcfp_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_DATA = 2'd1,
      PH_CRC  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_CRC_ERROR = 2'd1,
      ST_TOO_SHORT = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [31:0] frame_type;
      logic [31:0] frame_length;
      logic [1:0]  status;
      logic        last;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] le_insert(input logic [31:0] word, input logic [1:0] pos,
                                             input logic [7:0] b);
      logic [31:0] r;
      r = word;
      r[{pos, 3'b000} +: 8] = b;
      return r;
   endfunction

endpackage

@@ rtl/lcfp_parser.sv @@
// Frame parsing state and per-byte next-state and result logic.
module lcfp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output lcfp_pkg::result_type res
);
   import lcfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcrc_ff, rcrc_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] count_inc;
   logic        short_frame;

   assign count_inc   = count_ff + 32'd1;
   assign short_frame = (len_ff[31:2] == 30'd0);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      crc_in    = crc_ff;
      rcrc_in   = rcrc_ff;
      type_in   = type_ff;
      res_valid = 1'b0;
      res       = '0;
      case (phase_ff)
         PH_DATA: begin
            crc_in = crc_byte(crc_ff, rx_byte);
            if (count_ff[31:2] == 30'd0) begin
               type_in = le_insert(type_ff, count_ff[1:0], rx_byte);
            end else begin
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = rx_byte;
               res.frame_type   = type_ff;
               res.frame_length = len_ff;
               res.status       = ST_OK;
               res.last         = 1'b0;
            end
            if (count_inc == len_ff) begin
               phase_in = PH_CRC;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_CRC: begin
            rcrc_in  = le_insert(rcrc_ff, count_ff[1:0], rx_byte);
            count_in = count_inc;
            if (count_inc[31:2] != 30'd0) begin
               res_valid        = 1'b1;
               res.kind         = KIND_END;
               res.payload_byte = 8'd0;
               res.frame_type   = short_frame ? 32'd0 : type_ff;
               res.frame_length = len_ff;
               if (~crc_ff != rcrc_in) begin
                  res.status = ST_CRC_ERROR;
               end else if (short_frame) begin
                  res.status = ST_TOO_SHORT;
               end else begin
                  res.status = ST_OK;
               end
               res.last = 1'b1;
               phase_in = PH_LEN;
               count_in = '0;
               len_in   = '0;
               crc_in   = CRC_INIT;
               rcrc_in  = '0;
               type_in  = '0;
            end
         end
         default: begin
            phase_in = PH_LEN;
            len_in   = le_insert(len_ff, count_ff[1:0], rx_byte);
            count_in = count_inc;
            if (count_inc[31:2] != 30'd0) begin
               count_in = '0;
               phase_in = (len_in == 32'd0) ? PH_CRC : PH_DATA;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         count_ff <= '0;
         len_ff   <= '0;
         crc_ff   <= CRC_INIT;
         rcrc_ff  <= '0;
         type_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         rcrc_ff  <= rcrc_in;
         type_ff  <= type_in;
      end
   end

endmodule

@@ rtl/length_crc_frame_parser.sv @@
// Top level of the length-prefixed frame parser with CRC-32 check.
// Each req beat carries one byte of a stream of frames: a 4-byte little-endian
// length L, L data bytes and a 4-byte little-endian reflected CRC-32 over the data.
// The first four data bytes form the packet type; every later data byte leaves as a
// payload beat (kind 0), and after the last CRC byte one end beat (kind 1, last 1)
// gives status ok, CRC error or too short, with the length and the type (0 if L < 4).
// Payload of a frame whose end status is not ok must be dropped by the receiver. One
// byte is taken every cycle while req_stall is low; the bytewise CRC update and the
// 32-bit count compare finish in the accepting cycle; the output register holds the
// result, and a one-entry skid buffer behind it keeps req_stall a register output.
module length_crc_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_frame_type,
   output logic [31:0] rsp_frame_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import lcfp_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;
   logic       out_free;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   lcfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = accept & res_valid;
         out_in       = res;
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_frame_type   = out_ff.frame_type;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_status       = out_ff.status;
   assign rsp_last         = out_ff.last;

endmodule
